### hdl/ltc_pkg.sv
// Shared types and constants for the LRU translation cache.
`default_nettype none
package ltc_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int TAG_W        = 27;
   localparam int PTR_W        = 64;
   localparam int OCC_W        = 5;
   localparam int CMD_W        = 2;
   localparam int REQ_DATA_W   = 96;
   localparam int RSP_DATA_W   = 72;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_NOP     = 2'd0,
      ACT_PROMOTE = 2'd1,
      ACT_FILL    = 2'd2,
      ACT_REMOVE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SEL_MATCH  = 2'd0,
      SEL_FREE   = 2'd1,
      SEL_VICTIM = 2'd2
   } select_type;

   typedef struct packed {
      logic       search;
      action_type action;
      select_type select;
      logic       write_ptr;
   } ctrl_type;

   typedef struct packed {
      logic match_seen;
      logic free_seen;
   } chain_type;

endpackage
`default_nettype wire

### hdl/ltc_cell.sv
// One cache slot: tag compare, priority chain link and recency rank update.
`default_nettype none
module ltc_cell #(
   parameter int RANK_W = 4,
   parameter int ORW    = 5
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ltc_pkg::ctrl_type          ctrl,
   input  wire logic [ltc_pkg::TAG_W-1:0]  tag_bc,
   input  wire logic [ltc_pkg::PTR_W-1:0]  ptr_bc,
   input  wire logic [ORW-1:0]             old_rank,
   input  wire ltc_pkg::chain_type         chain_in,
   input  wire logic [ltc_pkg::PTR_W-1:0]  ptr_chain_in,
   input  wire logic [RANK_W-1:0]          rank_chain_in,
   output ltc_pkg::chain_type              chain_out,
   output logic [ltc_pkg::PTR_W-1:0]       ptr_chain_out,
   output logic [RANK_W-1:0]               rank_chain_out
);

   logic                      valid_ff, valid_in;
   logic [ltc_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic [ltc_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic [RANK_W-1:0]         rank_ff, rank_in;
   logic                      mfirst_ff, mfirst_in;
   logic                      ffirst_ff, ffirst_in;
   logic                      match;
   logic                      mfirst;
   logic                      sel;
   logic [ORW-1:0]            rank_ext;

   assign match     = valid_ff && (tag_ff == tag_bc);
   assign mfirst    = match && !chain_in.match_seen;
   assign rank_ext  = ORW'(rank_ff);

   assign chain_out.match_seen = chain_in.match_seen | match;
   assign chain_out.free_seen  = chain_in.free_seen | !valid_ff;
   assign ptr_chain_out  = ptr_chain_in | (mfirst ? ptr_ff : '0);
   assign rank_chain_out = rank_chain_in | (mfirst ? rank_ff : '0);

   always_comb begin
      case (ctrl.select)
         ltc_pkg::SEL_MATCH:  sel = mfirst_ff;
         ltc_pkg::SEL_FREE:   sel = ffirst_ff;
         ltc_pkg::SEL_VICTIM: sel = valid_ff && (rank_ext == old_rank);
         default:             sel = 1'b0;
      endcase
   end

   always_comb begin
      valid_in  = valid_ff;
      tag_in    = tag_ff;
      ptr_in    = ptr_ff;
      rank_in   = rank_ff;
      mfirst_in = mfirst_ff;
      ffirst_in = ffirst_ff;
      if (ctrl.search) begin
         mfirst_in = mfirst;
         ffirst_in = !valid_ff && !chain_in.free_seen;
      end
      case (ctrl.action)
         ltc_pkg::ACT_PROMOTE, ltc_pkg::ACT_FILL: begin
            if (sel) begin
               rank_in = '0;
               if (ctrl.write_ptr) begin
                  ptr_in = ptr_bc;
               end
               if (ctrl.action == ltc_pkg::ACT_FILL) begin
                  valid_in = 1'b1;
                  tag_in   = tag_bc;
               end
            end else if (valid_ff && rank_ext < old_rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         ltc_pkg::ACT_REMOVE: begin
            if (sel) begin
               valid_in = 1'b0;
            end else if (valid_ff && rank_ext > old_rank) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff    <= tag_in;
      ptr_ff    <= ptr_in;
      rank_ff   <= rank_in;
      mfirst_ff <= mfirst_in;
      ffirst_ff <= ffirst_in;
   end

endmodule
`default_nettype wire

### hdl/lru_translation_cache.sv
// Top level of the fully associative LRU translation cache.
//
// Each request, once accepted, passes a search state over the row of slot cells
// (tag compare and a priority chain that runs from slot 0 upward), then an update
// state in which every cell updates its own entry and recency rank. A new request
// is taken in the update cycle of the previous one, so the block can accept a new
// request before it is through with the last; the result sits in an output register
// and the block stalls in the update cycle only while an earlier result is still
// waiting. Rank 0 is the most recent entry; a full cache replaces the entry of
// highest rank. No clearing pass is needed after reset.
`default_nettype none
module lru_translation_cache #(
   parameter int CAPACITY = ltc_pkg::CAPACITY_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [26:0] page_number, [90:27] entry_pointer, [95:91] zero
   input  wire logic [ltc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  wire logic [ltc_pkg::CMD_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [63:0] found_pointer, [68:64] occupancy, [71:69] zero
   output logic [ltc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [0] hit
   output logic [0:0]                            rsp_tuser
);

   localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int ORW    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   state_type                   state_ff, state_in;
   ltc_pkg::cmd_type            cmd_ff, cmd_in;
   logic [ltc_pkg::TAG_W-1:0]   tag_ff, tag_in;
   logic [ltc_pkg::PTR_W-1:0]   ptr_ff, ptr_in;
   logic                        hit_ff, hit_in;
   logic [ltc_pkg::PTR_W-1:0]   stored_ff, stored_in;
   logic [ORW-1:0]              hrank_ff, hrank_in;
   logic [ORW-1:0]              count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [ltc_pkg::PTR_W-1:0]   rsp_ptr_ff, rsp_ptr_in;
   logic [ltc_pkg::OCC_W-1:0]   rsp_occ_ff, rsp_occ_in;

   logic                        accept;
   logic                        go;
   logic                        full;
   ltc_pkg::ctrl_type           ctrl;
   logic [ORW-1:0]              old_rank;
   logic [ORW-1:0]              count_next;
   logic [ltc_pkg::PTR_W-1:0]   found;
   logic                        hit_eff;

   ltc_pkg::chain_type          chain [CAPACITY+1];
   logic [ltc_pkg::PTR_W-1:0]   ptr_chain [CAPACITY+1];
   logic [RANK_W-1:0]           rank_chain [CAPACITY+1];

   assign chain[0].match_seen = 1'b0;
   assign chain[0].free_seen  = 1'b0;
   assign ptr_chain[0]        = '0;
   assign rank_chain[0]       = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ltc_cell #(
         .RANK_W (RANK_W),
         .ORW    (ORW)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .tag_bc         (tag_ff),
         .ptr_bc         (ptr_ff),
         .old_rank       (old_rank),
         .chain_in       (chain[i]),
         .ptr_chain_in   (ptr_chain[i]),
         .rank_chain_in  (rank_chain[i]),
         .chain_out      (chain[i+1]),
         .ptr_chain_out  (ptr_chain[i+1]),
         .rank_chain_out (rank_chain[i+1])
      );
   end

   assign go         = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_UPDATE && go);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == ORW'(CAPACITY));

   assign hit_eff = hit_ff && (cmd_ff == ltc_pkg::CMD_LOOKUP ||
                               cmd_ff == ltc_pkg::CMD_INSERT ||
                               cmd_ff == ltc_pkg::CMD_DELETE);

   always_comb begin
      ctrl.search    = (state_ff == ST_SEARCH);
      ctrl.action    = ltc_pkg::ACT_NOP;
      ctrl.select    = ltc_pkg::SEL_MATCH;
      ctrl.write_ptr = 1'b0;
      old_rank       = hrank_ff;
      count_next     = count_ff;
      found          = '0;
      case (cmd_ff)
         ltc_pkg::CMD_LOOKUP, ltc_pkg::CMD_INSERT: begin
            if (hit_eff) begin
               ctrl.action    = ltc_pkg::ACT_PROMOTE;
               ctrl.write_ptr = (ptr_ff != '0);
               found          = (ptr_ff != '0) ? ptr_ff : stored_ff;
            end else if (cmd_ff == ltc_pkg::CMD_INSERT) begin
               ctrl.action    = ltc_pkg::ACT_FILL;
               ctrl.write_ptr = 1'b1;
               if (full) begin
                  ctrl.select = ltc_pkg::SEL_VICTIM;
                  old_rank    = ORW'(CAPACITY - 1);
               end else begin
                  ctrl.select = ltc_pkg::SEL_FREE;
                  old_rank    = ORW'(CAPACITY);
                  count_next  = count_ff + 1'b1;
               end
            end
         end
         ltc_pkg::CMD_DELETE: begin
            if (hit_eff) begin
               ctrl.action = ltc_pkg::ACT_REMOVE;
               found       = stored_ff;
               count_next  = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!(state_ff == ST_UPDATE && go)) begin
         ctrl.action = ltc_pkg::ACT_NOP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      tag_in       = tag_ff;
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      stored_in    = stored_ff;
      hrank_in     = hrank_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ptr_in   = rsp_ptr_ff;
      rsp_occ_in   = rsp_occ_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         cmd_in = ltc_pkg::cmd_type'(req_tuser);
         tag_in = req_tdata[ltc_pkg::TAG_W-1:0];
         ptr_in = req_tdata[ltc_pkg::TAG_W +: ltc_pkg::PTR_W];
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            hit_in    = chain[CAPACITY].match_seen;
            stored_in = ptr_chain[CAPACITY];
            hrank_in  = ORW'(rank_chain[CAPACITY]);
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (go) begin
               count_in     = count_next;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_eff;
               rsp_ptr_in   = found;
               rsp_occ_in   = ltc_pkg::OCC_W'(count_next);
               state_in     = accept ? ST_SEARCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      tag_ff     <= tag_in;
      ptr_ff     <= ptr_in;
      hit_ff     <= hit_in;
      stored_ff  <= stored_in;
      hrank_ff   <= hrank_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_ptr_ff <= rsp_ptr_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(ltc_pkg::RSP_DATA_W - ltc_pkg::PTR_W - ltc_pkg::OCC_W){1'b0}},
                        rsp_occ_ff, rsp_ptr_ff};

endmodule
`default_nettype wire
